FILE: rtl/fat_type_layout_detect_macros.svh
// Assertion helpers for the FAT layout block.
`ifndef FAT_TYPE_LAYOUT_DETECT_MACROS_SVH
`define FAT_TYPE_LAYOUT_DETECT_MACROS_SVH
// Implication checked every clock, off while in reset.
`define FTL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%s failed", "lbl");
// Condition that must hold every clock out of reset.
`define FTL_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("%s failed", "lbl");
`endif

FILE: rtl/ftld_pkg.sv
package ftld_pkg;

  localparam int unsigned DivStages = 32;
  localparam int unsigned QueueDepth = 4;
  localparam logic [31:0] Fat12Limit = 32'd4085;
  localparam logic [31:0] Fat16Limit = 32'd65525;
  localparam int unsigned DirEntryShift = 5;

  typedef enum logic [1:0] {
    StatOk = 2'd0,
    StatExfat = 2'd1,
    StatBadSize = 2'd2,
    StatOverrun = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FmtFat12 = 2'd0,
    FmtFat16 = 2'd1,
    FmtFat32 = 2'd2
  } fat_format_e;

  typedef struct packed {
    logic        oem_is_exfat;
    logic [15:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [15:0] total_sectors_short;
    logic [31:0] total_sectors_long;
    logic [15:0] fat_size_short;
    logic [31:0] fat_size_long;
    logic [27:0] root_start_cluster;
  } bpb_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  fat_format;
    logic [31:0] sectors_per_fat;
    logic [31:0] volume_sectors;
    logic [15:0] first_fat_sector;
    logic [21:0] root_dir_sectors;
    logic [40:0] first_root_sector;
    logic [39:0] first_data_sector;
    logic [31:0] data_sectors;
    logic [31:0] cluster_count;
  } layout_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [1:0]  status;       // StatOk, StatExfat or StatBadSize
    logic [7:0]  spc;
    logic [15:0] resvd;
    logic [31:0] fatsz;
    logic [31:0] total;
    logic [21:0] rds;
    logic [39:0] fat_end;      // resvd + copies * fatsz
    logic [27:0] rclus_off;    // root cluster minus two, floored
  } front_t;

endpackage

FILE: rtl/ftld_if.sv
interface ftld_bpb_if;
  logic            valid;
  logic            ready;
  ftld_pkg::bpb_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftld_layout_if;
  logic              valid;
  logic              ready;
  ftld_pkg::layout_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ftld_fifo.sv
module ftld_fifo #(
  parameter int unsigned Depth = ftld_pkg::QueueDepth,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Cw = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Cw-1:0] cnt_q;
  logic push, pop;

  assign wr_ready_o = (cnt_q != Cw'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + Cw'(push) - Cw'(pop);
    end
  end
endmodule

FILE: rtl/ftld_divpipe.sv
// Pipelined restoring divider: one quotient bit per stage, with a
// sideband riding along. Stall by en_i only.
module ftld_divpipe #(
  parameter int unsigned Stages = ftld_pkg::DivStages,
  parameter int unsigned Dw = 16,
  parameter int unsigned Sw = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [Stages-1:0] num_i,
  input  logic [Dw-1:0]     den_i,
  input  logic [Sw-1:0]     side_i,
  output logic              valid_o,
  output logic [Stages-1:0] quo_o,
  output logic [Sw-1:0]     side_o
);
  logic [Stages-1:0] v_q;
  logic [Stages-1:0] n_q [Stages];
  logic [Dw-1:0]     r_q [Stages];
  logic [Dw-1:0]     d_q [Stages];
  logic [Sw-1:0]     s_q [Stages];

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic              v_in;
    logic [Stages-1:0] n_in;
    logic [Dw-1:0]     r_in;
    logic [Dw-1:0]     d_in;
    logic [Sw-1:0]     s_in;
    logic [Dw:0]       trial;
    logic              ge;

    if (g == 0) begin : g_first
      assign v_in = valid_i;
      assign n_in = num_i;
      assign r_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[g-1];
      assign n_in = n_q[g-1];
      assign r_in = r_q[g-1];
      assign d_in = d_q[g-1];
      assign s_in = s_q[g-1];
    end

    assign trial = {r_in, n_in[Stages-1]};
    assign ge = (trial >= {1'b0, d_in});
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[g] <= 1'b0;
      else if (en_i) v_q[g] <= v_in;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g] <= ge ? Dw'(trial - {1'b0, d_in}) : trial[Dw-1:0];
        n_q[g] <= {n_in[Stages-2:0], ge};
        d_q[g] <= d_in;
        s_q[g] <= s_in;
      end
    end
  end

  assign valid_o = v_q[Stages-1];
  assign quo_o = n_q[Stages-1];
  assign side_o = s_q[Stages-1];
endmodule

FILE: rtl/ftld_front.sv
// Front: rejects, selects the 16/32-bit fields and runs the root
// directory sector division in a pipeline.
module ftld_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  ftld_bpb_if.sink       in_if,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ftld_pkg::front_t out_data_o
);
  localparam int unsigned Stages = ftld_pkg::DivStages;

  // Stage 0 register: selection and the copies * fatsz product.
  logic                    s0_v_q;
  ftld_pkg::front_t        s0_q;
  logic [21:0]             s0_num_q;
  logic [15:0]             s0_bps_q;
  logic                    en;
  logic                    dv_valid;
  logic [21:0]             quo22;
  logic [Stages-1:0]       quo;
  ftld_pkg::front_t        dside;
  ftld_pkg::front_t        s0_d;
  ftld_pkg::bpb_t          b;
  logic                    out_v_q;
  ftld_pkg::front_t        out_d;
  ftld_pkg::front_t        out_q;

  // Whole pipeline moves when the output slot is free or leaving.
  assign en = !out_v_q || out_ready_i;
  assign in_if.ready = en;
  assign b = in_if.data;

  always_comb begin
    s0_d = '0;
    if (b.oem_is_exfat) begin
      s0_d.status = ftld_pkg::StatExfat;
    end else if (b.bytes_per_sector == '0 || b.sectors_per_cluster == '0) begin
      s0_d.status = ftld_pkg::StatBadSize;
    end else begin
      s0_d.status = ftld_pkg::StatOk;
    end
    s0_d.spc = b.sectors_per_cluster;
    s0_d.resvd = b.reserved_sectors;
    s0_d.fatsz = (b.fat_size_short != '0) ? 32'(b.fat_size_short) : b.fat_size_long;
    s0_d.total = (b.total_sectors_short != '0) ? 32'(b.total_sectors_short)
                                                : b.total_sectors_long;
    s0_d.fat_end = 40'(b.fat_copies) * 40'(s0_d.fatsz);
    s0_d.rclus_off = (b.root_start_cluster >= 28'd2) ? b.root_start_cluster - 28'd2 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_v_q <= 1'b0;
    else if (en) s0_v_q <= in_if.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
      s0_num_q <= (22'(b.root_entries) << ftld_pkg::DirEntryShift)
                  + 22'(b.bytes_per_sector) - 22'd1;
      s0_bps_q <= b.bytes_per_sector;
    end
  end

  ftld_divpipe #(.Stages(Stages), .Dw(16), .Sw($bits(ftld_pkg::front_t))) u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s0_v_q),
    .num_i(Stages'(s0_num_q)),
    .den_i((s0_bps_q == '0) ? 16'd1 : s0_bps_q),
    .side_i({s0_q.status, s0_q.spc, s0_q.resvd, s0_q.fatsz, s0_q.total, 22'd0,
             40'(s0_q.resvd) + s0_q.fat_end, s0_q.rclus_off}),
    .valid_o(dv_valid), .quo_o(quo), .side_o(dside)
  );

  assign quo22 = quo[21:0];

  always_comb begin
    out_d = dside;
    out_d.rds = quo22;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= dv_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;
endmodule

FILE: rtl/ftld_back.sv
`include "fat_type_layout_detect_macros.svh"
// Back: data start, overrun check, cluster division, type decision
// and the FAT32 re-layout.
module ftld_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ftld_pkg::front_t in_data_i,
  ftld_layout_if.source    out_if
);
  typedef struct packed {
    ftld_pkg::front_t f;
    logic [39:0]      fdata;
    logic             over;
  } b0_t;

  logic        en;
  logic        b0_v_q, b1_v_q, dv, dv2, b2_v_q, b3_v_q, out_v_q;
  b0_t         b0_q;
  logic [39:0] fdata_d;
  logic [31:0] q16, q32;
  b0_t         s16, s32;
  b0_t         b2_q;
  logic [31:0] c16_q, c32_q;
  logic [35:0] root_off_q;
  b0_t         b3_q;
  logic [31:0] c16b_q, c32b_q;
  logic        fat32_q;
  ftld_pkg::layout_t res_d, out_q;

  assign en = !out_v_q || out_if.ready;
  assign in_ready_o = en;
  assign fdata_d = in_data_i.fat_end + 40'(in_data_i.rds);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q <= 1'b0;
      b2_v_q <= 1'b0;
      b3_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b0_v_q <= in_valid_i;
      b2_v_q <= dv;
      b3_v_q <= b2_v_q;
      out_v_q <= b3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_q.f <= in_data_i;
      b0_q.fdata <= fdata_d;
      b0_q.over <= fdata_d > 40'(in_data_i.total);
    end
  end

  assign b1_v_q = b0_v_q;

  // Both candidate cluster counts divided in parallel.
  ftld_divpipe #(.Stages(32), .Dw(8), .Sw($bits(b0_t))) u_div16 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b1_v_q),
    .num_i(b0_q.over ? 32'd0 : b0_q.f.total - b0_q.fdata[31:0]),
    .den_i((b0_q.f.spc == '0) ? 8'd1 : b0_q.f.spc), .side_i(b0_q),
    .valid_o(dv), .quo_o(q16), .side_o(s16)
  );
  ftld_divpipe #(.Stages(32), .Dw(8), .Sw($bits(b0_t))) u_div32 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(b1_v_q),
    .num_i(b0_q.over ? 32'd0 : b0_q.f.total - b0_q.f.fat_end[31:0]),
    .den_i((b0_q.f.spc == '0) ? 8'd1 : b0_q.f.spc), .side_i(b0_q),
    .valid_o(dv2), .quo_o(q32), .side_o(s32)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q <= s16;
      c16_q <= q16;
      c32_q <= q32;
      b3_q <= b2_q;
      c16b_q <= c16_q;
      c32b_q <= c32_q;
      fat32_q <= c16_q >= ftld_pkg::Fat16Limit;
      root_off_q <= 36'(b2_q.f.rclus_off) * 36'(b2_q.f.spc);
    end
  end

  always_comb begin
    res_d = '0;
    res_d.status = b3_q.f.status;
    if (b3_q.f.status == ftld_pkg::StatOk) begin
      res_d.sectors_per_fat = b3_q.f.fatsz;
      res_d.volume_sectors = b3_q.f.total;
      res_d.first_fat_sector = b3_q.f.resvd;
      if (b3_q.over) begin
        res_d.status = ftld_pkg::StatOverrun;
        res_d.root_dir_sectors = b3_q.f.rds;
        res_d.first_root_sector = 41'(b3_q.f.fat_end);
        res_d.first_data_sector = b3_q.fdata;
      end else if (fat32_q) begin
        res_d.fat_format = ftld_pkg::FmtFat32;
        res_d.first_data_sector = b3_q.f.fat_end;
        res_d.first_root_sector = 41'(b3_q.f.fat_end) + 41'(root_off_q);
        res_d.data_sectors = b3_q.f.total - b3_q.f.fat_end[31:0];
        res_d.cluster_count = c32b_q;
      end else begin
        res_d.fat_format = (c16b_q < ftld_pkg::Fat12Limit) ? ftld_pkg::FmtFat12
                                                           : ftld_pkg::FmtFat16;
        res_d.root_dir_sectors = b3_q.f.rds;
        res_d.first_root_sector = 41'(b3_q.f.fat_end);
        res_d.first_data_sector = b3_q.fdata;
        res_d.data_sectors = b3_q.f.total - b3_q.fdata[31:0];
        res_d.cluster_count = c16b_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= res_d;
  end

  assign out_if.valid = out_v_q;
  assign out_if.data = out_q;

  `FTL_ASSERT_ALWAYS(a_div_lockstep, clk_i, rst_ni, dv == dv2)
  `FTL_ASSERT_IMP(a_div_side, clk_i, rst_ni, dv, s32 == s16)
  `FTL_ASSERT_IMP(a_hold_stall, clk_i, rst_ni, out_v_q && !out_if.ready, ##1 $stable(out_q))
  `FTL_ASSERT_IMP(a_fmt_range, clk_i, rst_ni, out_v_q,
    out_q.fat_format != 2'd3)
  `FTL_ASSERT_IMP(a_rej_zero, clk_i, rst_ni,
    out_v_q && (out_q.status == ftld_pkg::StatExfat || out_q.status == ftld_pkg::StatBadSize),
    out_q.cluster_count == '0 && out_q.volume_sectors == '0)
endmodule

FILE: rtl/fat_type_layout_detect.sv
// FAT volume layout detector. Takes one decoded boot-sector parameter
// block per item and returns one layout item: status, FAT type, FAT size,
// volume size, first FAT/root/data sectors, data sectors and cluster
// count. A new item is accepted every cycle while nothing stalls, since
// both dividers are fully pipelined. The path runs: in the front one
// select stage, 32 divider stages (root directory sectors) and an output
// slot, then the queue write, then in the back one data-start stage, 32
// divider stages (cluster count) and three more registers. Front and back
// are joined by a small queue so either side can stall alone; output
// holds while out_if.ready is low.
module fat_type_layout_detect #(
  parameter int unsigned QDepth = ftld_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ftld_bpb_if.sink      in_if,
  ftld_layout_if.source out_if
);
  logic             f_valid, f_ready, q_valid, q_ready;
  ftld_pkg::front_t f_data, q_data;

  ftld_front u_front (
    .clk_i, .rst_ni, .in_if,
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_data_o(f_data)
  );

  ftld_fifo #(.Depth(QDepth), .Width($bits(ftld_pkg::front_t))) u_q (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_data_i(f_data),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_data)
  );

  ftld_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .out_if
  );
endmodule

FILE: verif/testbench.sv
module testbench;
  import ftld_pkg::*;

  localparam int unsigned RandItems = 700;
  localparam int unsigned DrainCycles = 150;  // well past the pipeline latency
  localparam int unsigned CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  ftld_bpb_if    bpb_if ();
  ftld_layout_if lay_if ();

  fat_type_layout_detect u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (bpb_if),
    .out_if (lay_if)
  );

  // Layouts still owed by the block, oldest first.
  layout_t     layout_q[$];
  int unsigned mismatches = 0;
  int unsigned layouts_seen = 0;
  int unsigned cycles = 0;
  int unsigned fmt_seen[4];
  int unsigned stat_seen[4];
  // Idle odds, in percent, for the sender and the receiver.
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 56;

  // One directed stimulus row; want is typed in only where fixed is set.
  typedef struct {
    bpb_t    bpb;
    bit      fixed;
    layout_t want;
  } row_t;

  // Expected layout for one boot-sector record.
  function automatic layout_t predict_layout(bpb_t b);
    layout_t lay;
    longint unsigned fatsz, total, rds, froot, fdata, dsec, clus, off;
    lay = '0;
    if (b.oem_is_exfat) begin
      lay.status = StatExfat;
      return lay;
    end
    if (b.bytes_per_sector == 0 || b.sectors_per_cluster == 0) begin
      lay.status = StatBadSize;
      return lay;
    end
    fatsz = (b.fat_size_short != 0) ? 64'(b.fat_size_short) : 64'(b.fat_size_long);
    total = (b.total_sectors_short != 0) ? 64'(b.total_sectors_short)
                                         : 64'(b.total_sectors_long);
    rds = (64'(b.root_entries) * 64'd32 + 64'(b.bytes_per_sector) - 64'd1)
          / 64'(b.bytes_per_sector);
    froot = 64'(b.reserved_sectors) + 64'(b.fat_copies) * fatsz;
    fdata = froot + rds;
    lay.sectors_per_fat = fatsz[31:0];
    lay.volume_sectors = total[31:0];
    lay.first_fat_sector = b.reserved_sectors;
    if (fdata > total) begin
      // data region would start past the volume end: layout kept, no clusters
      lay.status = StatOverrun;
      lay.root_dir_sectors = rds[21:0];
      lay.first_root_sector = froot[40:0];
      lay.first_data_sector = fdata[39:0];
      return lay;
    end
    dsec = total - fdata;
    clus = dsec / 64'(b.sectors_per_cluster);
    if (clus >= 64'(Fat16Limit)) begin
      // FAT32: no fixed root area, root lives in the data region
      fdata = froot;
      dsec = total - fdata;
      clus = dsec / 64'(b.sectors_per_cluster);
      rds = 64'd0;
      off = (b.root_start_cluster >= 28'd2) ? 64'(b.root_start_cluster) - 64'd2 : 64'd0;
      froot = fdata + off * 64'(b.sectors_per_cluster);
      lay.fat_format = FmtFat32;
    end else if (clus < 64'(Fat12Limit)) begin
      lay.fat_format = FmtFat12;
    end else begin
      lay.fat_format = FmtFat16;
    end
    lay.status = StatOk;
    lay.root_dir_sectors = rds[21:0];
    lay.first_root_sector = froot[40:0];
    lay.first_data_sector = fdata[39:0];
    lay.data_sectors = dsec[31:0];
    lay.cluster_count = clus[31:0];
    return lay;
  endfunction

  task automatic report_field(string fname, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t mismatch %s: expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  // Output side: sampled mid-cycle, when everything is settled.
  always @(negedge clk_i) begin
    layout_t want, got;
    if (rst_ni && lay_if.valid && lay_if.ready) begin
      got = lay_if.data;
      layouts_seen++;
      if (layout_q.size() == 0) begin
        mismatches++;
        $display("%0t unexpected layout item, status %0d", $time, got.status);
      end else begin
        want = layout_q.pop_front();
        stat_seen[want.status]++;
        if (want.status == StatOk) fmt_seen[want.fat_format]++;
        report_field("status", want.status, got.status);
        report_field("fat_format", want.fat_format, got.fat_format);
        report_field("sectors_per_fat", want.sectors_per_fat, got.sectors_per_fat);
        report_field("volume_sectors", want.volume_sectors, got.volume_sectors);
        report_field("first_fat_sector", want.first_fat_sector, got.first_fat_sector);
        report_field("root_dir_sectors", want.root_dir_sectors, got.root_dir_sectors);
        report_field("first_root_sector", want.first_root_sector, got.first_root_sector);
        report_field("first_data_sector", want.first_data_sector, got.first_data_sector);
        report_field("data_sectors", want.data_sectors, got.data_sectors);
        report_field("cluster_count", want.cluster_count, got.cluster_count);
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    lay_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout, %0d layouts still owed", $time, layout_q.size());
      $display("[fat_type_layout_detect] ERROR");
      $finish;
    end
  end

  // Present one record, with random idle cycles ahead of it; returns after
  // the edge where it was taken, with the queue of layouts updated.
  task automatic send_bpb(bpb_t b, layout_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      bpb_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    bpb_if.valid <= 1'b1;
    bpb_if.data <= b;
    forever begin
      @(negedge clk_i);
      if (bpb_if.ready) break;
    end
    @(posedge clk_i);
    layout_q.push_back(want);
  endtask

  // Well-formed record aimed at one of the FAT types, or at an overrun.
  function automatic bpb_t make_bpb();
    bpb_t b;
    int unsigned pick;
    b.oem_is_exfat = ($urandom_range(19) == 0);
    b.bytes_per_sector = 16'd512 << $urandom_range(3);
    b.sectors_per_cluster = 8'd1 << $urandom_range(7);
    b.reserved_sectors = 16'($urandom_range(32));
    b.fat_copies = 8'($urandom_range(1, 2));
    b.root_entries = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'd512;
    b.total_sectors_long = $urandom();
    b.fat_size_long = $urandom();
    b.root_start_cluster = ($urandom_range(3) == 0) ? 28'($urandom())
                                                    : 28'($urandom_range(2, 40));
    pick = $urandom_range(9);
    if (pick < 3) begin
      // FAT12-sized: small 16-bit counts
      b.total_sectors_short = 16'($urandom_range(100, 65535));
      b.fat_size_short = 16'($urandom_range(1, 12));
    end else if (pick < 6) begin
      // FAT16-sized
      b.sectors_per_cluster = 8'd1 << $urandom_range(2);
      b.total_sectors_short = ($urandom_range(1) != 0) ? 16'($urandom_range(20000, 65535))
                                                       : 16'd0;
      b.total_sectors_long = $urandom_range(20000, 300000);
      b.fat_size_short = 16'($urandom_range(16, 256));
    end else if (pick < 9) begin
      // FAT32-sized: long counts
      b.total_sectors_short = 16'd0;
      b.fat_size_short = 16'd0;
      b.sectors_per_cluster = 8'd1 << $urandom_range(3);
      b.total_sectors_long = $urandom_range(600000, 32'hFFFF_FFF0);
      b.fat_size_long = $urandom_range(1, 20000);
    end else begin
      b.total_sectors_short = 16'($urandom_range(1, 200));
      b.fat_size_short = 16'($urandom_range(50, 65535));
    end
    // some noise: whole fields random
    if ($urandom_range(7) == 0) begin
      b.bytes_per_sector = 16'($urandom());
      b.sectors_per_cluster = 8'($urandom());
      b.reserved_sectors = 16'($urandom());
      b.fat_copies = 8'($urandom());
      b.root_entries = 16'($urandom());
      b.total_sectors_short = 16'($urandom());
      b.fat_size_short = 16'($urandom());
    end
    return b;
  endfunction

  initial begin
    row_t    rows[$];
    row_t    r;
    bpb_t    base;
    layout_t zero;
    int unsigned phase;

    bpb_if.valid = 1'b0;
    bpb_if.data = '0;
    lay_if.ready = 1'b0;
    zero = '0;

    // Directed rows. Base: 512 B sectors, 1 sector/cluster, 1 reserved,
    // one FAT of 1 sector, 16 root entries (one sector) -> data at sector 3.
    base = '0;
    base.bytes_per_sector = 16'd512;
    base.sectors_per_cluster = 8'd1;
    base.reserved_sectors = 16'd1;
    base.fat_copies = 8'd1;
    base.root_entries = 16'd16;
    base.fat_size_short = 16'd1;
    base.root_start_cluster = 28'd2;

    // exFAT wins, even with every other field at its maximum
    r.bpb = '1; r.fixed = 1'b1; r.want = zero; r.want.status = StatExfat; rows.push_back(r);
    // exFAT is checked ahead of a zero sector size
    r.bpb = '0; r.bpb.oem_is_exfat = 1'b1; rows.push_back(r);
    // zero sector size, zero cluster size, both
    r.bpb = base; r.bpb.bytes_per_sector = '0; r.want.status = StatBadSize; rows.push_back(r);
    r.bpb = base; r.bpb.sectors_per_cluster = '0; rows.push_back(r);
    r.bpb = '0; rows.push_back(r);
    r.fixed = 1'b0;
    // every field at its maximum, not exFAT
    r.bpb = '1; r.bpb.oem_is_exfat = 1'b0; rows.push_back(r);
    // classic 1.44 MB floppy
    r.bpb = base; r.bpb.fat_copies = 8'd2; r.bpb.root_entries = 16'd224;
    r.bpb.total_sectors_short = 16'd2880; r.bpb.fat_size_short = 16'd9; rows.push_back(r);
    // cluster count either side of the FAT12/FAT16 and FAT16/FAT32 limits
    r.bpb = base; r.bpb.total_sectors_short = 16'd4087; rows.push_back(r);
    r.bpb.total_sectors_short = 16'd4088; rows.push_back(r);
    r.bpb.total_sectors_short = 16'd65527; rows.push_back(r);
    r.bpb.total_sectors_short = 16'd65528; rows.push_back(r);
    // data start exactly at the volume end, then one past it
    r.bpb.total_sectors_short = 16'd3; rows.push_back(r);
    r.bpb.total_sectors_short = 16'd2; rows.push_back(r);
    // FAT32 through the long fields, root cluster 2, below 2 and at max
    r.bpb = base; r.bpb.root_entries = '0; r.bpb.fat_copies = 8'd2;
    r.bpb.sectors_per_cluster = 8'd8; r.bpb.reserved_sectors = 16'd32;
    r.bpb.fat_size_short = '0; r.bpb.fat_size_long = 32'd8000;
    r.bpb.total_sectors_long = 32'd2000000; rows.push_back(r);
    r.bpb.root_start_cluster = 28'd0; rows.push_back(r);
    r.bpb.root_start_cluster = 28'd1; rows.push_back(r);
    r.bpb.root_start_cluster = '1; r.bpb.sectors_per_cluster = '1; rows.push_back(r);
    // FAT32 on the largest volume, largest FAT that still fits
    r.bpb.total_sectors_long = '1; r.bpb.fat_copies = 8'd1;
    r.bpb.fat_size_long = 32'hFF00_0000; rows.push_back(r);
    // FAT so large it overruns the volume: the widest first sectors
    r.bpb = '1; r.bpb.oem_is_exfat = 1'b0; r.bpb.fat_size_short = '0;
    r.bpb.bytes_per_sector = 16'd1; rows.push_back(r);
    // short counts of zero with long counts of zero
    r.bpb = base; r.bpb.fat_size_short = '0; rows.push_back(r);
    // sector size 1 with full root directory: largest root area
    r.bpb = base; r.bpb.bytes_per_sector = 16'd1; r.bpb.root_entries = '1;
    r.bpb.total_sectors_short = '0; r.bpb.total_sectors_long = '1; rows.push_back(r);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_bpb(rows[i].bpb, rows[i].fixed ? rows[i].want : predict_layout(rows[i].bpb));
    end

    // Random part in three idling phases; before the last one the sender
    // holds off until every owed layout has come back.
    for (phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 56;
        recv_idle_pct = 32;
      end else if (phase == 2) begin
        bpb_if.valid <= 1'b0;
        while (layout_q.size() != 0) @(posedge clk_i);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      repeat (RandItems / 3) begin
        base = make_bpb();
        send_bpb(base, predict_layout(base));
      end
    end
    bpb_if.valid <= 1'b0;

    while (layout_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("checked %0d layouts: ok %0d, exfat %0d, bad size %0d, overrun %0d",
             layouts_seen, stat_seen[StatOk], stat_seen[StatExfat],
             stat_seen[StatBadSize], stat_seen[StatOverrun]);
    $display("types: FAT12 %0d, FAT16 %0d, FAT32 %0d; %0d mismatches",
             fmt_seen[FmtFat12], fmt_seen[FmtFat16], fmt_seen[FmtFat32], mismatches);
    if (mismatches == 0 && layout_q.size() == 0) begin
      $display("[fat_type_layout_detect] OK");
    end else begin
      $display("[fat_type_layout_detect] ERROR");
    end
    $finish;
  end

endmodule
